// ----- hw/rtl/optt_pkg.sv -----
// ----------------------------------------------------------------------------
// optt_pkg
// Shared types and codes for the one-shot / periodic timer table.
// ----------------------------------------------------------------------------
package optt_pkg;

  localparam int TIME_MAX_BITS = 64;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_FULL  = 3'd1;
  localparam logic [2:0] KIND_FIRED = 3'd2;
  localparam logic [2:0] KIND_WAIT  = 3'd3;
  localparam logic [2:0] KIND_DONE  = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] now_time;
    logic [31:0] delay_time;
    logic [31:0] period_time;
    logic [7:0]  slot_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  timer_index;
    logic [47:0] wait_time;
    logic        no_timer;
    logic [4:0]  fired_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]               op;
    logic [TIME_MAX_BITS-1:0] now;
    logic [TIME_MAX_BITS-1:0] due;
    logic [31:0]              period;
    logic [7:0]               sid;
  } cmd_rec_t;

  typedef struct packed {
    logic     valid;
    cmd_rec_t rec;
  } cmd_chan_t;

endpackage

// ----- hw/rtl/oneshot_periodic_timer_table.sv -----
// Add and cancel are handled in the idle state of the table sequencer; an add
// writes its result beat into the result queue as its command is popped.
// Tick and query walk the allocated slots in the scan state, one slot per
// cycle while the result queue has room, through the registered read port of the timer memories.
// Synchronous reset clears live bits, allocation count and both queues;
// timer memories are not cleared and hold nothing until a slot is added.
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_table
// Table of one-shot and periodic millisecond timers with add, cancel,
// tick and query commands over queue-style command and result ports.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_table
  import optt_pkg::*;
#(
  parameter int TIMERS    = 16,
  parameter int TIME_BITS = 48
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  cmd_chan_t cq;
  logic      cmd_pop;
  logic      res_room;
  logic      res_push;
  out_item_t res_item;

  optt_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .cmd_pop(cmd_pop),
    .cq     (cq)
  );

  optt_back #(
    .TIMERS   (TIMERS),
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cq      (cq),
    .cmd_pop (cmd_pop),
    .res_room(res_room),
    .res_push(res_push),
    .res_item(res_item)
  );

  optt_resq u_resq (
    .clk     (clk),
    .rst     (rst),
    .res_push(res_push),
    .res_item(res_item),
    .res_room(res_room),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ----- hw/rtl/optt_front.sv -----
// ----------------------------------------------------------------------------
// optt_front
// Accepts commands, precomputes the saturated due time of an add and
// holds decoded commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module optt_front
  import optt_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  input  logic      cmd_pop,
  output cmd_chan_t cq
);

  localparam int TW = TIME_BITS;

  logic [TW-1:0] now_t;
  logic [TW:0]   due_sum;
  logic [TW-1:0] due_t;
  cmd_rec_t      rec;

  cmd_rec_t   q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       wr;
  logic       rd;

  // saturating now + delay
  assign now_t   = TW'(item.now_time);
  assign due_sum = {1'b0, now_t} + (TW + 1)'(item.delay_time);
  assign due_t   = due_sum[TW] ? {TW{1'b1}} : due_sum[TW-1:0];

  always_comb begin
    rec        = '0;
    rec.op     = item.cmd;
    rec.now    = TIME_MAX_BITS'(now_t);
    rec.due    = TIME_MAX_BITS'(due_t);
    rec.period = item.period_time;
    rec.sid    = item.slot_id;
  end

  assign full = (cnt == 2'd2);
  assign wr   = push && !full;
  assign rd   = cmd_pop && (cnt != 2'd0);

  assign cq.valid = (cnt != 2'd0);
  assign cq.rec   = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= rec;
    end
  end

endmodule

// ----- hw/rtl/optt_back.sv -----
// ----------------------------------------------------------------------------
// optt_back
// Timer table and scan sequencer: allocates and cancels slots, walks the
// allocated slots one per cycle while the result queue has room for tick and query, and emits results.
// ----------------------------------------------------------------------------
module optt_back
  import optt_pkg::*;
#(
  parameter int TIMERS    = 16,
  parameter int TIME_BITS = 48
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_chan_t cq,
  output logic      cmd_pop,
  input  logic      res_room,
  output logic      res_push,
  output out_item_t res_item
);

  localparam int AW = $clog2(TIMERS);
  localparam int CW = $clog2(TIMERS + 1);
  localparam int TW = TIME_BITS;
  localparam int SW = (CW > 8) ? CW : 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [TW-1:0] due_mem [TIMERS];
  logic [31:0]   per_mem [TIMERS];
  logic [TW-1:0] due_rd;
  logic [31:0]   per_rd;

  logic [TIMERS-1:0] live;
  logic [CW-1:0]     used;
  logic [1:0]        state;
  logic              scan_query;
  logic [TW-1:0]     now_r;
  logic [CW-1:0]     ip;
  logic              ev_v;
  logic [AW-1:0]     ev_i;
  logic [CW-1:0]     fired;
  logic              found;
  logic [TW-1:0]     best;

  logic          is_full;
  logic          sid_ok;
  logic          idle_go;
  logic          adv;
  logic          issue;
  logic          scan_end;
  logic          fire;
  logic [TW:0]   sum_due;
  logic [TW:0]   sum_now;
  logic [TW-1:0] sat_due;
  logic [TW-1:0] sat_now;
  logic [TW-1:0] new_due;
  logic [TW-1:0] wait_v;
  logic          due_we;
  logic [AW-1:0] due_waddr;
  logic [TW-1:0] due_wdata;
  logic          per_we;

  assign is_full  = (used == CW'(TIMERS));
  assign sid_ok   = (SW'(cq.rec.sid) < SW'(used));
  assign idle_go  = (state == ST_IDLE) && cq.valid && res_room;
  assign cmd_pop  = idle_go;
  assign adv      = (state == ST_SCAN) && res_room;
  assign issue    = adv && (ip < used);
  assign scan_end = adv && !ev_v && !(ip < used);

  // next due time of a periodic slot, both candidates in parallel
  assign sum_due = {1'b0, due_rd} + (TW + 1)'(per_rd);
  assign sum_now = {1'b0, now_r} + (TW + 1)'(per_rd);
  assign sat_due = sum_due[TW] ? {TW{1'b1}} : sum_due[TW-1:0];
  assign sat_now = sum_now[TW] ? {TW{1'b1}} : sum_now[TW-1:0];
  assign new_due = (sat_due <= now_r) ? sat_now : sat_due;

  assign fire   = ev_v && !scan_query && live[ev_i] && !(due_rd > now_r);
  assign wait_v = (found && (best > now_r)) ? (best - now_r) : '0;

  assign due_we    = (idle_go && (cq.rec.op == CMD_ADD) && !is_full) ||
                     (adv && fire && (per_rd != 32'd0));
  assign due_waddr = (state == ST_IDLE) ? used[AW-1:0] : ev_i;
  assign due_wdata = (state == ST_IDLE) ? cq.rec.due[TW-1:0] : new_due;
  assign per_we    = idle_go && (cq.rec.op == CMD_ADD) && !is_full;

  always_comb begin
    res_push = 1'b0;
    res_item = '0;
    case (state)
      ST_IDLE: begin
        if (idle_go && (cq.rec.op == CMD_ADD)) begin
          res_push             = 1'b1;
          res_item.kind        = is_full ? KIND_FULL : KIND_ALLOC;
          res_item.timer_index = is_full ? 4'd0 : 4'(used);
          res_item.last        = 1'b1;
        end
      end
      ST_SCAN: begin
        if (adv && fire) begin
          res_push             = 1'b1;
          res_item.kind        = KIND_FIRED;
          res_item.timer_index = 4'(ev_i);
        end
      end
      ST_DONE: begin
        if (res_room) begin
          res_push      = 1'b1;
          res_item.last = 1'b1;
          if (scan_query) begin
            res_item.kind      = KIND_WAIT;
            res_item.wait_time = 48'(wait_v);
            res_item.no_timer  = !found;
          end else begin
            res_item.kind        = KIND_DONE;
            res_item.fired_count = 5'(fired);
          end
        end
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      live  <= '0;
      used  <= '0;
      ev_v  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (idle_go) begin
            case (cq.rec.op)
              CMD_ADD: begin
                if (!is_full) begin
                  live[used[AW-1:0]] <= 1'b1;
                  used               <= used + 1'b1;
                end
              end
              CMD_CANCEL: begin
                if (sid_ok) begin
                  live[cq.rec.sid[AW-1:0]] <= 1'b0;
                end
              end
              default: begin
                state      <= ST_SCAN;
                scan_query <= (cq.rec.op == CMD_QUERY);
                now_r      <= cq.rec.now[TW-1:0];
                ip         <= '0;
                fired      <= '0;
                found      <= 1'b0;
                ev_v       <= 1'b0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (adv) begin
            ev_v <= issue;
            if (issue) begin
              ip   <= ip + 1'b1;
              ev_i <= ip[AW-1:0];
            end
            if (fire) begin
              fired <= fired + 1'b1;
              if (per_rd == 32'd0) begin
                live[ev_i] <= 1'b0;
              end
            end
            if (ev_v && scan_query && live[ev_i] && (!found || (due_rd < best))) begin
              best  <= due_rd;
              found <= 1'b1;
            end
            if (scan_end) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (res_room) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // timer memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[due_waddr] <= due_wdata;
    end
    if (per_we) begin
      per_mem[used[AW-1:0]] <= cq.rec.period;
    end
    if (issue) begin
      due_rd <= due_mem[ip[AW-1:0]];
      per_rd <= per_mem[ip[AW-1:0]];
    end
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(TIMERS))
    else $error("allocation count beyond table size");

  a_eval_allocated: assert property (@(posedge clk) disable iff (rst)
    ev_v |-> (CW'(ev_i) < used))
    else $error("evaluating an unallocated slot");

  a_idle_no_eval: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ev_v)
    else $error("scan stage busy while idle");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_room)
    else $error("result pushed into a full queue");

  a_fired_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (fired <= used))
    else $error("fired count beyond allocated slots");
`endif

endmodule

// ----- hw/rtl/optt_resq.sv -----
// ----------------------------------------------------------------------------
// optt_resq
// Two-entry result queue between the scan sequencer and the consumer.
// ----------------------------------------------------------------------------
module optt_resq
  import optt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      res_push,
  input  out_item_t res_item,
  output logic      res_room,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  out_item_t  q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       wr;
  logic       rd;

  assign res_room = (cnt != 2'd2);
  assign empty    = (cnt == 2'd0);
  assign wr       = res_push && res_room;
  assign rd       = pop && !empty;
  assign result   = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= res_item;
    end
  end

endmodule
